### hw/rtl/bps_pkg.sv
// Shared types and constants for the button PWM setting controller.
// Depends on nothing; bps_debounce and top level use scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

    localparam int NUM_BUTTONS = 5;

    localparam int CNT_W   = 16;
    localparam int THR_W   = 16;
    localparam int CLK_W   = 29;
    localparam int FREQ_W  = 17;
    localparam int DUTY_W  = 7;
    localparam int CHAN_W  = 3;
    localparam int ACT_W   = 3;
    localparam int REL_W   = 16;
    localparam int PROD_W  = DUTY_W + FREQ_W;
    localparam int PCT_W   = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0]  CNT_MAX       = '1;
    localparam logic [FREQ_W-1:0] FREQ_STEP     = 17'd5000;
    localparam logic [FREQ_W-1:0] FREQ_MAX      = 17'd100000;
    localparam logic [FREQ_W-1:0] FREQ_RESET    = 17'd50000;
    localparam logic [DUTY_W-1:0] DUTY_STEP     = 7'd5;
    localparam logic [DUTY_W-1:0] DUTY_MAX      = 7'd100;
    localparam logic [DUTY_W-1:0] DUTY_RESET    = 7'd50;
    localparam logic [CHAN_W-1:0] CHANNEL_FIRST = 3'd0;
    localparam logic [CHAN_W-1:0] CHANNEL_OFF   = 3'd4;
    localparam logic [REL_W-1:0]  RELOAD_RESET  = 16'd1679;
    localparam logic [PCT_W-1:0]  PERCENT       = 7'd100;
    localparam logic [THR_W-1:0]  THRESHOLD_RESET = 16'd50;
    localparam logic [CLK_W-1:0]  CLOCK_RESET   = 29'd84000000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_CLOCK     = 1'd1;

    typedef enum logic [ACT_W-1:0] {
        ACT_FREQ_DOWN    = 3'd0,
        ACT_CHANNEL_NEXT = 3'd1,
        ACT_FREQ_UP      = 3'd2,
        ACT_DUTY_UP      = 3'd3,
        ACT_DUTY_DOWN    = 3'd4
    } action_t;

    typedef struct packed {
        logic    hit;
        action_t action;
    } press_event_t;

endpackage

`default_nettype wire

### hw/rtl/bps_debounce.sv
// Per-button debounce counters and fixed-priority press detection.
// Depends on bps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bps_debounce #(
    parameter int NUM_BUTTONS = bps_pkg::NUM_BUTTONS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic [NUM_BUTTONS-1:0]       press,
    input  wire logic [bps_pkg::THR_W-1:0]    threshold,
    output bps_pkg::press_event_t             event_out
);

    logic [bps_pkg::CNT_W-1:0] cnt_reg  [NUM_BUTTONS];
    logic [bps_pkg::CNT_W-1:0] cnt_next [NUM_BUTTONS];
    bps_pkg::press_event_t     evt_reg;
    bps_pkg::press_event_t     evt_next;

    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            if (press[i])
            begin
                cnt_next[i] = (cnt_reg[i] == bps_pkg::CNT_MAX) ?
                              cnt_reg[i] : cnt_reg[i] + 1'b1;
            end
            else
            begin
                cnt_next[i] = (cnt_reg[i] != '0) ? cnt_reg[i] - 1'b1 : cnt_reg[i];
            end
        end
        // scan from the back so the lowest index wins
        evt_next.hit    = 1'b0;
        evt_next.action = bps_pkg::ACT_FREQ_DOWN;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--)
        begin
            if (cnt_next[i] >= threshold)
            begin
                evt_next.hit    = 1'b1;
                evt_next.action = bps_pkg::action_t'(bps_pkg::ACT_W'(i));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            evt_reg <= '0;
        end
        else if (accept)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                cnt_reg[i] <= evt_next.hit ? '0 : cnt_next[i];
            end
            evt_reg <= evt_next;
        end
    end

    assign event_out = evt_reg;

endmodule

`default_nettype wire

### hw/rtl/bps_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, low bits kept.
// Depends on nothing outside itself.
`timescale 1ns / 1ps
`default_nettype none

module bps_div #(
    parameter int DVD_W = 29,
    parameter int DSR_W = 17,
    parameter int QUO_W = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DSR_W-1:0] divisor,
    output logic                  done,
    output logic [QUO_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  dvd_reg;
    logic [DSR_W-1:0]  dsr_reg;
    logic [DSR_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              run_reg;
    logic              done_reg;
    logic [DSR_W:0]    rem_shift;
    logic              qbit;
    logic [DSR_W:0]    rem_diff;

    always_comb
    begin
        // partial remainder stays below the divisor, so the shift cannot overflow
        rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        qbit      = (rem_shift >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= run_reg && (step_reg == STEP_W'(1));
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= STEP_W'(DVD_W);
            end
            else if (run_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= qbit ? rem_diff[DSR_W-1:0] : rem_shift[DSR_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### hw/rtl/bps_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Depends on nothing outside itself.
`timescale 1ns / 1ps
`default_nettype none

module bps_mul #(
    parameter int A_W = 7,
    parameter int B_W = 17
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [A_W-1:0]   a,
    input  wire logic [B_W-1:0]   b,
    output logic                  done,
    output logic [A_W+B_W-1:0]    product
);

    localparam int P_W    = A_W + B_W;
    localparam int STEP_W = $clog2(A_W + 1);

    logic [A_W-1:0]    a_reg;
    logic [P_W-1:0]    b_reg;
    logic [P_W-1:0]    acc_reg;
    logic [STEP_W-1:0] step_reg;
    logic              run_reg;
    logic              done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= run_reg && (step_reg == STEP_W'(1));
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= STEP_W'(A_W);
            end
            else if (run_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= P_W'(b);
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            if (a_reg[0])
            begin
                acc_reg <= acc_reg + b_reg;
            end
            a_reg <= a_reg >> 1;
            b_reg <= b_reg << 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

### hw/rtl/button_pwm_setting_controller.sv
// Top level of the button PWM setting controller: settings state, sequencer,
// serial divide and multiply units. Depends on bps_pkg, bps_debounce,
// bps_div and bps_mul.
//
// Usage: drive one input word per millisecond tick on in_valid/in_ready with
// the five sampled button levels. Each tick moves the debounce counters; a
// tick whose counters reach press_threshold applies one action and yields
// one output word on out_valid/out_ready, any other tick yields none.
// A press that leaves the frequency at zero goes straight to out_valid; any
// other press first runs the clock/frequency divider, the duty multiplier
// and the divide by 100, one after another. One tick is in flight at a
// time, so a press tick occupies the block until its output handshake.
// in_ready is high only while the block waits for a tick. If the receiver
// stalls, the output word holds and no new tick is taken until it is read.
// Reset clears the counters, loads frequency 50000, duty 50, channel 0,
// reload 1679, threshold 50 and timer clock 84000000. The cfg port writes a
// register on any cycle with cfg_write high; write it only while idle.
`timescale 1ns / 1ps
`default_nettype none

module button_pwm_setting_controller #(
    parameter int NUM_BUTTONS = bps_pkg::NUM_BUTTONS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [bps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bps_pkg::CLK_W-1:0]       cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            press_freq_down,
    input  wire logic                            press_channel_next,
    input  wire logic                            press_freq_up,
    input  wire logic                            press_duty_up,
    input  wire logic                            press_duty_down,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [bps_pkg::ACT_W-1:0]            action_taken,
    output logic [bps_pkg::CHAN_W-1:0]           output_channel,
    output logic [bps_pkg::FREQ_W-1:0]           frequency_hz,
    output logic [bps_pkg::DUTY_W-1:0]           duty_percent,
    output logic [bps_pkg::REL_W-1:0]            period_reload,
    output logic [bps_pkg::REL_W-1:0]            compare_value
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_APPLY    = 6'b000010,
        ST_DIVIDE   = 6'b000100,
        ST_MULTIPLY = 6'b001000,
        ST_SCALE    = 6'b010000,
        ST_SEND     = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [bps_pkg::THR_W-1:0]  threshold_reg;
    logic [bps_pkg::CLK_W-1:0]  clock_reg;
    logic [bps_pkg::FREQ_W-1:0] freq_reg;
    logic [bps_pkg::FREQ_W-1:0] freq_next;
    logic [bps_pkg::DUTY_W-1:0] duty_reg;
    logic [bps_pkg::DUTY_W-1:0] duty_next;
    logic [bps_pkg::CHAN_W-1:0] chan_reg;
    logic [bps_pkg::CHAN_W-1:0] chan_next;
    logic [bps_pkg::REL_W-1:0]  reload_reg;
    logic [bps_pkg::REL_W-1:0]  compare_reg;
    logic [bps_pkg::FREQ_W:0]   freq_sum;
    logic [bps_pkg::DUTY_W:0]   duty_sum;

    logic                       in_accept;
    logic [NUM_BUTTONS-1:0]     press;
    bps_pkg::press_event_t      evt;

    logic                       div_start;
    logic                       div_done;
    logic [bps_pkg::REL_W-1:0]  div_quo;
    logic                       mul_start;
    logic                       mul_done;
    logic [bps_pkg::FREQ_W-1:0] mul_b;
    logic [bps_pkg::PROD_W-1:0] mul_prod;
    logic                       pct_start;
    logic                       pct_done;
    logic [bps_pkg::REL_W-1:0]  pct_quo;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign press     = {press_duty_down, press_duty_up, press_freq_up,
                        press_channel_next, press_freq_down};

    bps_debounce #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_debounce (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .press     (press),
        .threshold (threshold_reg),
        .event_out (evt)
    );

    // next settings for the latched action
    always_comb
    begin
        freq_next = freq_reg;
        duty_next = duty_reg;
        chan_next = chan_reg;
        freq_sum  = {1'b0, freq_reg} + {1'b0, bps_pkg::FREQ_STEP};
        duty_sum  = {1'b0, duty_reg} + {1'b0, bps_pkg::DUTY_STEP};
        case (evt.action)
            bps_pkg::ACT_FREQ_DOWN:
            begin
                if (freq_reg >= bps_pkg::FREQ_STEP)
                begin
                    freq_next = freq_reg - bps_pkg::FREQ_STEP;
                end
            end
            bps_pkg::ACT_CHANNEL_NEXT:
            begin
                chan_next = (chan_reg >= bps_pkg::CHANNEL_OFF) ?
                            bps_pkg::CHANNEL_FIRST : chan_reg + 1'b1;
            end
            bps_pkg::ACT_FREQ_UP:
            begin
                freq_next = (freq_sum > {1'b0, bps_pkg::FREQ_MAX}) ?
                            bps_pkg::FREQ_MAX : freq_sum[bps_pkg::FREQ_W-1:0];
            end
            bps_pkg::ACT_DUTY_UP:
            begin
                duty_next = (duty_sum > {1'b0, bps_pkg::DUTY_MAX}) ?
                            bps_pkg::DUTY_MAX : duty_sum[bps_pkg::DUTY_W-1:0];
            end
            default:
            begin
                if (duty_reg >= bps_pkg::DUTY_STEP)
                begin
                    duty_next = duty_reg - bps_pkg::DUTY_STEP;
                end
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        mul_start  = 1'b0;
        pct_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (!evt.hit)
                begin
                    state_next = ST_IDLE;
                end
                else if (freq_next == '0)
                begin
                    state_next = ST_SEND;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_MULTIPLY;
                end
            end
            ST_MULTIPLY:
            begin
                if (mul_done)
                begin
                    pct_start  = 1'b1;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (pct_done)
                begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // reload + 1 is the raw quotient, except that a zero quotient stands for 65536
    assign mul_b = (div_quo == '0) ? {1'b1, {bps_pkg::REL_W{1'b0}}} : {1'b0, div_quo};

    bps_div #(
        .DVD_W (bps_pkg::CLK_W),
        .DSR_W (bps_pkg::FREQ_W),
        .QUO_W (bps_pkg::REL_W)
    ) u_period_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (clock_reg),
        .divisor  (freq_next),
        .done     (div_done),
        .quotient (div_quo)
    );

    bps_mul #(
        .A_W (bps_pkg::DUTY_W),
        .B_W (bps_pkg::FREQ_W)
    ) u_duty_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (duty_reg),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    bps_div #(
        .DVD_W (bps_pkg::PROD_W),
        .DSR_W (bps_pkg::PCT_W),
        .QUO_W (bps_pkg::REL_W)
    ) u_percent_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pct_start),
        .dividend (mul_prod),
        .divisor  (bps_pkg::PERCENT),
        .done     (pct_done),
        .quotient (pct_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            threshold_reg <= bps_pkg::THRESHOLD_RESET;
            clock_reg     <= bps_pkg::CLOCK_RESET;
            freq_reg      <= bps_pkg::FREQ_RESET;
            duty_reg      <= bps_pkg::DUTY_RESET;
            chan_reg      <= bps_pkg::CHANNEL_FIRST;
            reload_reg    <= bps_pkg::RELOAD_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    bps_pkg::REG_PRESS_THRESHOLD:
                    begin
                        threshold_reg <= cfg_data[bps_pkg::THR_W-1:0];
                    end
                    bps_pkg::REG_TIMER_CLOCK:
                    begin
                        clock_reg <= cfg_data;
                    end
                    default:
                    begin
                        clock_reg <= clock_reg;
                    end
                endcase
            end
            if (state_reg == ST_APPLY && evt.hit)
            begin
                freq_reg <= freq_next;
                duty_reg <= duty_next;
                chan_reg <= chan_next;
            end
            if (state_reg == ST_DIVIDE && div_done)
            begin
                reload_reg <= div_quo - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_APPLY)
        begin
            compare_reg <= '0;
        end
        else if (state_reg == ST_SCALE && pct_done)
        begin
            compare_reg <= (chan_reg >= bps_pkg::CHANNEL_OFF) ? '0 : pct_quo;
        end
    end

    assign out_valid      = (state_reg == ST_SEND);
    assign action_taken   = evt.action;
    assign output_channel = chan_reg;
    assign frequency_hz   = freq_reg;
    assign duty_percent   = duty_reg;
    assign period_reload  = reload_reg;
    assign compare_value  = compare_reg;

endmodule

`default_nettype wire
